// ===== hdl/dda_pkg.sv =====
package dda_pkg;

  // table dimensions
  localparam int SENDER_SLOTS       = 128;
  localparam int NUMBERS_PER_SENDER = 20;
  localparam int SLOT_W   = (SENDER_SLOTS > 1) ? $clog2(SENDER_SLOTS) : 1;
  localparam int WALK_W   = $clog2(SENDER_SLOTS + 1);
  localparam int CNT_W    = $clog2(NUMBERS_PER_SENDER + 1);
  localparam int NUM_DEPTH = SENDER_SLOTS * NUMBERS_PER_SENDER;
  localparam int NUM_AW   = (NUM_DEPTH > 1) ? $clog2(NUM_DEPTH) : 1;

  // protocol constants
  localparam logic [15:0] TIMEOUT_RESET = 16'd30;
  localparam logic [10:0] MIN_DATAGRAM  = 11'd23;
  localparam logic [10:0] MAX_DATAGRAM  = 11'd1472;
  localparam logic [10:0] PROBE_LENGTH  = 11'd3;

  // item class decided at the front
  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_PROBE,
    KIND_DROP,
    KIND_DATA
  } item_kind_t;

  // queued item
  typedef struct packed {
    item_kind_t  kind;
    logic [31:0] now;
    logic [47:0] key;
    logic [31:0] num;
  } q_item_t;

  // back sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AGE,
    ST_CNT_RD,
    ST_CNT_WAIT,
    ST_DUP,
    ST_STORE,
    ST_EMIT_RD,
    ST_EMIT_OUT,
    ST_PROBE
  } back_state_t;

endpackage

// ===== hdl/datagram_dedup_ack_table.sv =====
// channel | handshake            | payload
// in      | in_valid / in_stall  | func, now_seconds, sender_ip, sender_port,
//         |                      | datagram_length, starts_with_put, message_number
// out     | out_valid / out_stall| reply_kind, ack_number, ack_position, last_of_run
// cfg     | cfg_valid / cfg_ready| cfg_data (timeout_seconds)
//
// one item at a time: an idle state, then the aging and lookup walk over all 128 slots;
// a known sender adds the count read and a duplicate scan over its n stored numbers,
// then a store state and, per acknowledgement, a read state and an output state.
// a two-entry input queue keeps accepting while the back end works, until it is full.
// synchronous active-low reset clears slot valid bits; no clearing pass.
// a stalled output holds its result and the sequencer waits on it.
module datagram_dedup_ack_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [31:0] in_now_seconds,
  input  logic [31:0] in_sender_ip,
  input  logic [15:0] in_sender_port,
  input  logic [10:0] in_datagram_length,
  input  logic        in_starts_with_put,
  input  logic [31:0] in_message_number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_reply_kind,
  output logic [31:0] out_ack_number,
  output logic [4:0]  out_ack_position,
  output logic        out_last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic [15:0]      timeout_r, timeout_nxt;
  logic             q_valid;
  logic             q_pop;
  dda_pkg::q_item_t q_item;

  // timeout register transfer
  assign cfg_ready   = 1'b1;
  assign timeout_nxt = (cfg_valid && cfg_ready) ? cfg_data : timeout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= dda_pkg::TIMEOUT_RESET;
    end else begin
      timeout_r <= timeout_nxt;
    end
  end

  // classify and queue
  dda_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_now_seconds     (in_now_seconds),
    .in_sender_ip       (in_sender_ip),
    .in_sender_port     (in_sender_port),
    .in_datagram_length (in_datagram_length),
    .in_starts_with_put (in_starts_with_put),
    .in_message_number  (in_message_number),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .q_pop              (q_pop)
  );

  // table walk and acknowledgement run
  dda_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .timeout          (timeout_r),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_reply_kind   (out_reply_kind),
    .out_ack_number   (out_ack_number),
    .out_ack_position (out_ack_position),
    .out_last_of_run  (out_last_of_run)
  );

endmodule

// ===== hdl/dda_front.sv =====
module dda_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_func,
  input  logic [31:0]      in_now_seconds,
  input  logic [31:0]      in_sender_ip,
  input  logic [15:0]      in_sender_port,
  input  logic [10:0]      in_datagram_length,
  input  logic             in_starts_with_put,
  input  logic [31:0]      in_message_number,
  output logic             q_valid,
  output dda_pkg::q_item_t q_item,
  input  logic             q_pop
);

  dda_pkg::q_item_t fifo_r [2];
  dda_pkg::q_item_t new_item;
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;
  logic [10:0]      len_sat;
  logic             push;

  // length saturation and classification
  always_comb begin
    len_sat = (in_datagram_length > dda_pkg::MAX_DATAGRAM) ?
              dda_pkg::MAX_DATAGRAM : in_datagram_length;
    new_item.now = in_now_seconds;
    new_item.key = {in_sender_ip, in_sender_port};
    new_item.num = in_message_number;
    priority if (!in_func) begin
      new_item.kind = dda_pkg::KIND_TICK;
    end else if (len_sat == dda_pkg::PROBE_LENGTH && in_starts_with_put) begin
      new_item.kind = dda_pkg::KIND_PROBE;
    end else if (len_sat < dda_pkg::MIN_DATAGRAM) begin
      new_item.kind = dda_pkg::KIND_DROP;
    end else begin
      new_item.kind = dda_pkg::KIND_DATA;
    end
  end

  // two-entry queue
  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = fifo_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

// ===== hdl/dda_back.sv =====
module dda_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [15:0]      timeout,
  input  logic             q_valid,
  input  dda_pkg::q_item_t q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_reply_kind,
  output logic [31:0]      out_ack_number,
  output logic [4:0]       out_ack_position,
  output logic             out_last_of_run
);

  localparam int SLOTS  = dda_pkg::SENDER_SLOTS;
  localparam int NPS    = dda_pkg::NUMBERS_PER_SENDER;
  localparam int SLOT_W = dda_pkg::SLOT_W;
  localparam int WALK_W = dda_pkg::WALK_W;
  localparam int CNT_W  = dda_pkg::CNT_W;
  localparam int NUM_AW = dda_pkg::NUM_AW;

  // memories
  logic [47:0]      addr_mem [SLOTS];
  logic [31:0]      last_mem [SLOTS];
  logic [CNT_W-1:0] cnt_mem  [SLOTS];
  logic [31:0]      num_mem  [dda_pkg::NUM_DEPTH];
  logic [47:0]      addr_q;
  logic [31:0]      last_q;
  logic [CNT_W-1:0] cnt_q;
  logic [31:0]      num_q;

  dda_pkg::back_state_t state_r, state_nxt;

  logic [SLOTS-1:0]  valid_r, valid_nxt;
  logic [WALK_W-1:0] ai_r, ai_nxt;
  logic              chk_v_r, chk_v_nxt;
  logic [SLOT_W-1:0] chk_idx_r, chk_idx_nxt;
  logic              hit_v_r, hit_v_nxt;
  logic [SLOT_W-1:0] hit_idx_r, hit_idx_nxt;
  logic              free_v_r, free_v_nxt;
  logic [SLOT_W-1:0] free_idx_r, free_idx_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [NUM_AW-1:0] base_r, base_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  di_r, di_nxt;
  logic [CNT_W-1:0]  ei_r, ei_nxt;
  logic              dup_r, dup_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_kind_r, out_kind_nxt;
  logic [31:0]       out_num_r, out_num_nxt;
  logic [4:0]        out_pos_r, out_pos_nxt;
  logic              out_last_r, out_last_nxt;

  // memory controls
  logic [SLOT_W-1:0] walk_ra;
  logic [SLOT_W-1:0] sel_slot;
  logic              addr_we, last_we, cnt_we, num_we;
  logic [CNT_W-1:0]  cnt_wd;
  logic [NUM_AW-1:0] num_ra, num_wa;

  // shared conditions
  logic              walk_done, dup_done, out_free, emit_last, aged;
  logic [31:0]       idle_time;
  logic [CNT_W-1:0]  ei_inc;
  logic [CNT_W+4:0]  ei_ext;

  assign walk_done = (ai_r == WALK_W'(SLOTS)) && !chk_v_r;
  assign dup_done  = (di_r == cnt_r) && !chk_v_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign ei_inc    = ei_r + 1'b1;
  assign emit_last = (ei_inc == cnt_r);
  assign ei_ext    = (CNT_W + 5)'(ei_r);
  assign idle_time = q_item.now - last_q;
  assign aged      = (idle_time > {16'd0, timeout});
  assign walk_ra   = ai_r[SLOT_W-1:0];
  assign sel_slot  = hit_v_r ? hit_idx_r : free_idx_r;
  assign num_ra    = base_r + NUM_AW'((state_r == dda_pkg::ST_DUP) ? di_r : ei_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dda_pkg::ST_IDLE: begin
        if (q_valid) state_nxt = dda_pkg::ST_AGE;
      end
      dda_pkg::ST_AGE: begin
        if (walk_done) begin
          unique case (q_item.kind)
            dda_pkg::KIND_PROBE: state_nxt = dda_pkg::ST_PROBE;
            dda_pkg::KIND_DATA: begin
              priority if (hit_v_r) state_nxt = dda_pkg::ST_CNT_RD;
              else if (free_v_r)    state_nxt = dda_pkg::ST_STORE;
              else                  state_nxt = dda_pkg::ST_IDLE;
            end
            default: state_nxt = dda_pkg::ST_IDLE;
          endcase
        end
      end
      dda_pkg::ST_CNT_RD:   state_nxt = dda_pkg::ST_CNT_WAIT;
      dda_pkg::ST_CNT_WAIT: state_nxt = dda_pkg::ST_DUP;
      dda_pkg::ST_DUP: begin
        if (dup_done) state_nxt = dda_pkg::ST_STORE;
      end
      dda_pkg::ST_STORE:    state_nxt = dda_pkg::ST_EMIT_RD;
      dda_pkg::ST_EMIT_RD:  state_nxt = dda_pkg::ST_EMIT_OUT;
      dda_pkg::ST_EMIT_OUT: begin
        if (out_free) state_nxt = emit_last ? dda_pkg::ST_IDLE : dda_pkg::ST_EMIT_RD;
      end
      dda_pkg::ST_PROBE: begin
        if (out_free) state_nxt = dda_pkg::ST_IDLE;
      end
      default: state_nxt = dda_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory strobes
  always_comb begin
    valid_nxt     = valid_r;
    ai_nxt        = ai_r;
    chk_v_nxt     = chk_v_r;
    chk_idx_nxt   = chk_idx_r;
    hit_v_nxt     = hit_v_r;
    hit_idx_nxt   = hit_idx_r;
    free_v_nxt    = free_v_r;
    free_idx_nxt  = free_idx_r;
    slot_nxt      = slot_r;
    base_nxt      = base_r;
    cnt_nxt       = cnt_r;
    di_nxt        = di_r;
    ei_nxt        = ei_r;
    dup_nxt       = dup_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_num_nxt   = out_num_r;
    out_pos_nxt   = out_pos_r;
    out_last_nxt  = out_last_r;
    addr_we       = 1'b0;
    last_we       = 1'b0;
    cnt_we        = 1'b0;
    num_we        = 1'b0;
    cnt_wd        = cnt_r + 1'b1;
    num_wa        = base_r + NUM_AW'(cnt_r);
    q_pop         = (state_r != dda_pkg::ST_IDLE) && (state_nxt == dda_pkg::ST_IDLE);
    unique case (state_r)
      dda_pkg::ST_IDLE: begin
        ai_nxt     = '0;
        chk_v_nxt  = 1'b0;
        hit_v_nxt  = 1'b0;
        free_v_nxt = 1'b0;
      end
      dda_pkg::ST_AGE: begin
        // issue the next slot read
        if (ai_r != WALK_W'(SLOTS)) begin
          ai_nxt      = ai_r + 1'b1;
          chk_v_nxt   = 1'b1;
          chk_idx_nxt = walk_ra;
        end else begin
          chk_v_nxt = 1'b0;
        end
        // check the slot read last cycle
        if (chk_v_r) begin
          if (valid_r[chk_idx_r] && !aged) begin
            if (addr_q == q_item.key) begin
              hit_v_nxt   = 1'b1;
              hit_idx_nxt = chk_idx_r;
            end
          end else begin
            valid_nxt[chk_idx_r] = 1'b0;
            if (!free_v_r) begin
              free_v_nxt   = 1'b1;
              free_idx_nxt = chk_idx_r;
            end
          end
        end
        // claim or allocate the sender slot
        if (walk_done && q_item.kind == dda_pkg::KIND_DATA &&
            (hit_v_r || free_v_r)) begin
          slot_nxt = sel_slot;
          base_nxt = NUM_AW'(sel_slot * NPS);
          last_we  = 1'b1;
          if (!hit_v_r) begin
            addr_we             = 1'b1;
            valid_nxt[sel_slot] = 1'b1;
            cnt_nxt             = '0;
            dup_nxt             = 1'b0;
          end
        end
      end
      dda_pkg::ST_CNT_RD: begin
      end
      dda_pkg::ST_CNT_WAIT: begin
        cnt_nxt   = cnt_q;
        di_nxt    = '0;
        chk_v_nxt = 1'b0;
        dup_nxt   = 1'b0;
      end
      dda_pkg::ST_DUP: begin
        if (di_r != cnt_r) begin
          di_nxt    = di_r + 1'b1;
          chk_v_nxt = 1'b1;
        end else begin
          chk_v_nxt = 1'b0;
        end
        if (chk_v_r && num_q == q_item.num) dup_nxt = 1'b1;
      end
      dda_pkg::ST_STORE: begin
        ei_nxt = '0;
        if (!dup_r && cnt_r < CNT_W'(NPS)) begin
          num_we  = 1'b1;
          cnt_we  = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      dda_pkg::ST_EMIT_RD: begin
      end
      dda_pkg::ST_EMIT_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = 1'b0;
          out_num_nxt   = num_q;
          out_pos_nxt   = ei_ext[4:0];
          out_last_nxt  = emit_last;
          ei_nxt        = ei_inc;
        end
      end
      dda_pkg::ST_PROBE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = 1'b1;
          out_num_nxt   = '0;
          out_pos_nxt   = '0;
          out_last_nxt  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dda_pkg::ST_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    ai_r       <= ai_nxt;
    chk_v_r    <= chk_v_nxt;
    chk_idx_r  <= chk_idx_nxt;
    hit_v_r    <= hit_v_nxt;
    hit_idx_r  <= hit_idx_nxt;
    free_v_r   <= free_v_nxt;
    free_idx_r <= free_idx_nxt;
    slot_r     <= slot_nxt;
    base_r     <= base_nxt;
    cnt_r      <= cnt_nxt;
    di_r       <= di_nxt;
    ei_r       <= ei_nxt;
    dup_r      <= dup_nxt;
    out_kind_r <= out_kind_nxt;
    out_num_r  <= out_num_nxt;
    out_pos_r  <= out_pos_nxt;
    out_last_r <= out_last_nxt;
  end

  // sender tables
  always_ff @(posedge clk) begin
    if (addr_we) addr_mem[sel_slot] <= q_item.key;
    if (last_we) last_mem[sel_slot] <= q_item.now;
    if (cnt_we)  cnt_mem[slot_r]    <= cnt_wd;
    addr_q <= addr_mem[walk_ra];
    last_q <= last_mem[walk_ra];
    cnt_q  <= cnt_mem[slot_r];
  end

  // stored number table
  always_ff @(posedge clk) begin
    if (num_we) num_mem[num_wa] <= q_item.num;
    num_q <= num_mem[num_ra];
  end

  assign out_valid        = out_valid_r;
  assign out_reply_kind   = out_kind_r;
  assign out_ack_number   = out_num_r;
  assign out_ack_position = out_pos_r;
  assign out_last_of_run  = out_last_r;

endmodule

// ===== tb/tb.sv =====
module tb;

  localparam int LIMIT = 600000;
  localparam int SETTLE = 400;

  // predictor of the sender table and queue of expected acks
  class ack_scoreboard;
    typedef struct {
      bit        kind;
      bit [31:0] num;
      bit [4:0]  pos;
      bit        last;
    } ack_t;

    bit [15:0] timeout;
    bit [47:0] key_tab[dda_pkg::SENDER_SLOTS];
    bit [31:0] seen_tab[dda_pkg::SENDER_SLOTS];
    int        cnt_tab[dda_pkg::SENDER_SLOTS];
    bit [31:0] num_tab[dda_pkg::SENDER_SLOTS][dda_pkg::NUMBERS_PER_SENDER];
    int        senders;
    ack_t      pending[$];
    int        errors;

    function new();
      timeout = dda_pkg::TIMEOUT_RESET;
      senders = 0;
      errors  = 0;
    endfunction

    // drop idle senders, closing the gaps in order
    function void age(bit [31:0] now);
      int keep;
      bit [31:0] idle;
      keep = 0;
      for (int i = 0; i < senders; i++) begin
        idle = now - seen_tab[i];
        if (idle > {16'd0, timeout}) continue;
        if (keep != i) begin
          key_tab[keep]  = key_tab[i];
          seen_tab[keep] = seen_tab[i];
          cnt_tab[keep]  = cnt_tab[i];
          num_tab[keep]  = num_tab[i];
        end
        keep++;
      end
      senders = keep;
    endfunction

    function void note_item(bit func, bit [31:0] now, bit [31:0] ip, bit [15:0] port,
                            bit [10:0] len, bit put, bit [31:0] num);
      bit [47:0] key;
      int idx;
      bit dup;
      ack_t a;
      key = {ip, port};
      age(now);
      if (!func) return;
      if (len > dda_pkg::MAX_DATAGRAM) len = dda_pkg::MAX_DATAGRAM;
      if (len == dda_pkg::PROBE_LENGTH && put) begin
        a.kind = 1; a.num = 0; a.pos = 0; a.last = 1;
        pending.push_back(a);
        return;
      end
      if (len < dda_pkg::MIN_DATAGRAM) return;
      idx = senders;
      for (int i = 0; i < senders; i++)
        if (key_tab[i] == key) begin
          idx = i;
          break;
        end
      if (idx == senders) begin
        if (senders >= dda_pkg::SENDER_SLOTS) return;
        senders++;
        key_tab[idx] = key;
        cnt_tab[idx] = 0;
      end
      seen_tab[idx] = now;
      dup = 0;
      for (int i = 0; i < cnt_tab[idx]; i++)
        if (num_tab[idx][i] == num) dup = 1;
      if (!dup && cnt_tab[idx] < dda_pkg::NUMBERS_PER_SENDER) begin
        num_tab[idx][cnt_tab[idx]] = num;
        cnt_tab[idx]++;
      end
      for (int i = 0; i < cnt_tab[idx]; i++) begin
        a.kind = 0;
        a.num  = num_tab[idx][i];
        a.pos  = i[4:0];
        a.last = (i + 1 == cnt_tab[idx]);
        pending.push_back(a);
      end
    endfunction

    function void check_result(bit kind, bit [31:0] num, bit [4:0] pos, bit last);
      ack_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result kind %0d num %h pos %0d last %0d",
                 $time, kind, num, pos, last);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.kind != kind) begin
        $display("%0t: reply_kind expected %0d actual %0d", $time, e.kind, kind);
        errors++;
      end
      if (e.num != num) begin
        $display("%0t: ack_number expected %h actual %h", $time, e.num, num);
        errors++;
      end
      if (e.pos != pos) begin
        $display("%0t: ack_position expected %0d actual %0d", $time, e.pos, pos);
        errors++;
      end
      if (e.last != last) begin
        $display("%0t: last_of_run expected %0d actual %0d", $time, e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_func;
  logic [31:0] in_now_seconds;
  logic [31:0] in_sender_ip;
  logic [15:0] in_sender_port;
  logic [10:0] in_datagram_length;
  logic        in_starts_with_put;
  logic [31:0] in_message_number;
  logic        out_valid;
  logic        out_stall;
  logic        out_reply_kind;
  logic [31:0] out_ack_number;
  logic [4:0]  out_ack_position;
  logic        out_last_of_run;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  ack_scoreboard sb = new();
  bit        quiet = 0;
  int        cycles = 0;
  int        hold = 0;
  bit [31:0] tnow;
  bit [47:0] pool[8];

  datagram_dedup_ack_table DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_now_seconds(in_now_seconds), .in_sender_ip(in_sender_ip),
    .in_sender_port(in_sender_port), .in_datagram_length(in_datagram_length),
    .in_starts_with_put(in_starts_with_put), .in_message_number(in_message_number),
    .out_valid(out_valid), .out_stall(out_stall), .out_reply_kind(out_reply_kind),
    .out_ack_number(out_ack_number), .out_ack_position(out_ack_position),
    .out_last_of_run(out_last_of_run),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial clk = 0;
  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: random stall bursts, check every transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_reply_kind, out_ack_number, out_ack_position, out_last_of_run);
    if (hold > 0) begin
      hold <= hold - 1;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      out_stall <= 1;
      hold <= $urandom_range(0, 5);
    end else begin
      out_stall <= 0;
      hold <= quiet ? 0 : $urandom_range(0, 10);
    end
  end

  // one input transfer; valid stays high for the caller to lower, unless a random gap lowers it
  task send(bit func, bit [31:0] now, bit [47:0] key, bit [10:0] len, bit put,
            bit [31:0] num);
    in_valid           <= 1;
    in_func            <= func;
    in_now_seconds     <= now;
    in_sender_ip       <= key[47:16];
    in_sender_port     <= key[15:0];
    in_datagram_length <= len;
    in_starts_with_put <= put;
    in_message_number  <= num;
    do @(posedge clk); while (in_stall);
    sb.note_item(func, now, key[47:16], key[15:0], len, put, num);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // wait out all acks and any silent item still in the block
  task drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task write_timeout(bit [15:0] value);
    cfg_valid <= 1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.timeout = value;
  endtask

  task send_random();
    bit        func;
    bit [47:0] key;
    bit [10:0] len;
    bit        put;
    bit [31:0] num;
    int        r;
    func = ($urandom_range(0, 9) != 0);
    r = $urandom_range(0, 19);
    if (r == 0) tnow = tnow + sb.timeout + 1 + $urandom_range(0, 4);
    else if (r == 1) tnow = $urandom;
    else tnow = tnow + $urandom_range(0, 2);
    if ($urandom_range(0, 7) != 0) key = pool[$urandom_range(0, 3)];
    else if ($urandom_range(0, 1)) key = pool[$urandom_range(4, 7)];
    else key = {$urandom, 16'($urandom)};
    put = $urandom_range(0, 1);
    r = $urandom_range(0, 9);
    if (r == 0) len = dda_pkg::PROBE_LENGTH;
    else if (r == 1) len = $urandom_range(0, 22);
    else if (r == 2) len = $urandom_range(1473, 2047);
    else len = $urandom_range(23, 1472);
    num = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 23);
    send(func, tnow, key, len, put, num);
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0; in_func = 0; in_now_seconds = 0; in_sender_ip = 0;
    in_sender_port = 0; in_datagram_length = 0; in_starts_with_put = 0;
    in_message_number = 0; out_stall = 0; cfg_valid = 0; cfg_data = 0;
    for (int i = 0; i < 8; i++) pool[i] = {$urandom, 16'($urandom)};
    repeat (3) @(posedge clk);
    rst_n <= 1;

    // directed: probe, short drops, store, duplicate, saturation, aging, wrap
    tnow = 0;
    send(1, 0, pool[0], dda_pkg::PROBE_LENGTH, 1, 32'h1234);
    send(1, 0, pool[0], dda_pkg::PROBE_LENGTH, 0, 0);
    send(1, 0, pool[0], 11'd0, 1, 0);
    send(1, 0, pool[0], 11'd22, 0, 0);
    send(1, 0, pool[0], 11'd23, 0, 0);
    send(1, 1, pool[0], 11'd23, 1, 0);
    send(1, 2, 48'hFFFF_FFFF_FFFF, 11'd2047, 0, 32'hFFFF_FFFF);
    send(1, 3, 48'h0, dda_pkg::MAX_DATAGRAM, 0, 32'h8000_0001);
    send(0, 32, pool[1], 11'd0, 0, 0);
    send(1, 33, pool[0], 11'd100, 0, 7);
    send(0, 34, 48'hFFFF_FFFF_FFFF, 11'd2047, 1, 32'hFFFF_FFFF);
    send(1, 32'hFFFF_FFF0, pool[1], 11'd64, 0, 5);
    send(1, 32'd5, pool[1], 11'd64, 0, 6);
    send(1, 32'd6, pool[0], 11'd1473, 1, 7);
    send(0, 32'd200, pool[0], 11'd0, 0, 0);
    drain();

    // random traffic with a random timeout
    write_timeout(16'($urandom_range(0, 200)));
    repeat (10) send_random();
    drain();

    // no idling: age everything, one sender past its list, then fill the table
    quiet = 1;
    write_timeout(16'hFFFF);
    tnow = tnow + 32'd70000;
    send(0, tnow, pool[0], 11'd0, 0, 0);
    for (int i = 0; i < dda_pkg::NUMBERS_PER_SENDER + 2; i++)
      send(1, tnow, pool[2], 11'd40, 0, i % (dda_pkg::NUMBERS_PER_SENDER + 1));
    for (int i = 0; i < dda_pkg::SENDER_SLOTS; i++)
      send(1, tnow, {$urandom, 16'(i)}, 11'd100, 0, $urandom);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
